// ===== hw/rtl/swerm_pkg.sv =====
// Shared types and constants for the sliding-window event rate monitor.
// No dependencies; imported by swerm_stamp_ring and the top level.
package swerm_pkg;

    // default sizes
    localparam int DEF_MAX_EVENTS = 256;
    localparam int DEF_TIME_BITS  = 32;

    // configuration register widths and indexes
    localparam int WIN_W     = 31;
    localparam int THR_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = WIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WARN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FATAL  = 2'd3;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 31'd1000;

    // result level codes
    typedef enum logic [1:0] {
        LVL_OK    = 2'd0,
        LVL_WARN  = 2'd1,
        LVL_ERROR = 2'd2,
        LVL_FATAL = 2'd3
    } level_t;

    // tick control into the stamp ring
    typedef struct packed {
        logic step;      // a tick word is accepted this cycle
        logic event_in;  // that tick carries an event
    } ring_ctrl_t;

    // tick status out of the stamp ring
    typedef struct packed {
        logic dropped;   // event lost, ring full
        logic expired;   // oldest stamp retired this tick
    } ring_stat_t;

endpackage

// ===== hw/rtl/swerm_stamp_ring.sv =====
// Ring of event tick stamps held in a synchronous memory, with pointers and fill count.
// Depends on swerm_pkg. The stamp at the tail is prefetched every cycle.
module swerm_stamp_ring import swerm_pkg::*; #(
    parameter int MAX_EVENTS = DEF_MAX_EVENTS,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ring_ctrl_t                      ctrl,
    input  logic [TIME_BITS-1:0]            now,
    input  logic [WIN_W-1:0]                win,
    output logic [$clog2(MAX_EVENTS+1)-1:0] count_next,
    output ring_stat_t                      stat
);

    localparam int IDX_W = $clog2(MAX_EVENTS);
    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam int CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

    logic [TIME_BITS-1:0] stamp_mem [MAX_EVENTS];

    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_BITS-1:0] tail_stamp_reg;

    logic [TIME_BITS-1:0] age;
    logic [CNT_W-1:0]     cnt_after;
    logic                 expire;
    logic                 full;
    logic                 push;

    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        ring_inc = (idx == IDX_W'(MAX_EVENTS - 1)) ? '0 : idx + 1'b1;
    endfunction

    // expire the oldest stamp, then store this tick's event
    always_comb
    begin
        age        = now - tail_stamp_reg;
        expire     = ctrl.step && (count_reg != '0) && (CMP_W'(age) >= CMP_W'(win));
        cnt_after  = count_reg - CNT_W'(expire);
        full       = (cnt_after == CNT_W'(MAX_EVENTS));
        push       = ctrl.step && ctrl.event_in && !full;
        tail_next  = expire ? ring_inc(tail_reg) : tail_reg;
        head_next  = push ? ring_inc(head_reg) : head_reg;
        count_next = cnt_after + CNT_W'(push);
        stat.dropped = ctrl.step && ctrl.event_in && full;
        stat.expired = expire;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // stamp memory: one write, one registered read of the next tail entry;
    // a write to that same entry is forwarded
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stamp_mem[head_reg] <= now;
        end
        if (push && (head_reg == tail_next))
        begin
            tail_stamp_reg <= now;
        end
        else
        begin
            tail_stamp_reg <= stamp_mem[tail_next];
        end
    end

endmodule

// ===== hw/rtl/sliding_window_event_rate_monitor_top.sv =====
// Top level of the sliding-window event rate monitor: tick counter, thresholds, result word.
// Depends on swerm_pkg and swerm_stamp_ring.
//
// Each input word is one time tick and one is taken every cycle unless a held result
// word is stalled at the output; its result word appears in the output register on the
// next cycle and input keeps flowing while that register is drained in the same cycle.
// The rate is set by a single read-modify-write of the stamp memory per tick: the tail
// stamp is prefetched into a read register each cycle, with a write of that same entry
// forwarded. The stamp memory needs no clearing pass after reset, so words are taken
// from the first cycle out of reset.
module sliding_window_event_rate_monitor_top import swerm_pkg::*; #(
    parameter int MAX_EVENTS = DEF_MAX_EVENTS,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // tick input
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 event_seen,
    // result output
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 rate_valid,
    output logic [8:0]           event_count,
    output logic [1:0]           level,
    output logic                 event_dropped
);

    localparam int CNT_W = $clog2(MAX_EVENTS + 1);
    localparam int CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;
    localparam int LV_W  = (CNT_W > THR_W) ? CNT_W : THR_W;

    logic [WIN_W-1:0]     window_reg;
    logic [THR_W-1:0]     warn_reg, error_reg, fatal_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic                 filled_reg, filled_next;

    logic                 out_valid_reg;
    logic                 out_rate_valid_reg;
    logic [8:0]           out_count_reg;
    level_t               out_level_reg;
    logic                 out_dropped_reg;

    logic                 accept;
    logic [WIN_W-1:0]     win;
    ring_ctrl_t           ring_ctrl;
    ring_stat_t           ring_stat;
    logic [CNT_W-1:0]     count_next;
    logic [LV_W-1:0]      cnt_ext;
    logic [8:0]           cnt_sat;
    level_t               level_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            warn_reg   <= '0;
            error_reg  <= '0;
            fatal_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW: window_reg <= cfg_data[WIN_W-1:0];
                REG_WARN:   warn_reg   <= cfg_data[THR_W-1:0];
                REG_ERROR:  error_reg  <= cfg_data[THR_W-1:0];
                REG_FATAL:  fatal_reg  <= cfg_data[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // a zero window acts as one tick
    assign win = (window_reg == '0) ? WIN_W'(1) : window_reg;

    assign ring_ctrl.step     = accept;
    assign ring_ctrl.event_in = event_seen;

    swerm_stamp_ring #(
        .MAX_EVENTS (MAX_EVENTS),
        .TIME_BITS  (TIME_BITS)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ring_ctrl),
        .now        (now_reg),
        .win        (win),
        .count_next (count_next),
        .stat       (ring_stat)
    );

    // window fill, count saturation and level choice
    always_comb
    begin
        filled_next = filled_reg || (CMP_W'(now_reg) >= CMP_W'(win));
        cnt_ext     = LV_W'(count_next);
        cnt_sat     = (cnt_ext > LV_W'(511)) ? 9'd511 : cnt_ext[8:0];
        level_next  = LVL_OK;
        if (filled_next)
        begin
            if (cnt_ext < LV_W'(fatal_reg))
                level_next = LVL_FATAL;
            else if (cnt_ext < LV_W'(error_reg))
                level_next = LVL_ERROR;
            else if (cnt_ext < LV_W'(warn_reg))
                level_next = LVL_WARN;
            else
                level_next = LVL_OK;
        end
    end

    // tick counter and sticky window flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else if (accept)
        begin
            now_reg    <= now_reg + 1'b1;
            filled_reg <= filled_next;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_rate_valid_reg <= filled_next;
            out_count_reg      <= cnt_sat;
            out_level_reg      <= level_next;
            out_dropped_reg    <= ring_stat.dropped;
        end
    end

    assign out_valid     = out_valid_reg;
    assign rate_valid    = out_rate_valid_reg;
    assign event_count   = out_count_reg;
    assign level         = out_level_reg;
    assign event_dropped = out_dropped_reg;

endmodule
